[design/hcs_pkg.sv]
// Package for harvest_cycle_statistics: widths, motion codes, register
// indexes, divider operation codes and controller/datapath structs.
// No dependencies.
package hcs_pkg;

  localparam int TimeBitsDef = 48;
  localparam int TimeInW     = 48;
  localparam int CfgW        = 48;
  localparam int CfgIdxW     = 3;
  localparam int DivisorW    = 16;
  localparam logic [47:0] GapLimitRst = 48'd600000;
  localparam logic [15:0] TreeMax     = 16'hFFFF;
  localparam logic [15:0] CsScale     = 16'd100;
  // floor(x / 100) == (x * CsRecip) >> CsRecipShift for x below 25600
  localparam logic [14:0] CsRecip      = 15'd20972;
  localparam int          CsRecipShift = 21;

  localparam logic [2:0] MOT_STILL     = 3'd0;
  localparam logic [2:0] MOT_CLOSING   = 3'd2;
  localparam logic [2:0] MOT_VIBRATING = 3'd3;
  localparam logic [2:0] MOT_OPENING   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BACKWARD = 2'd1;
  localparam logic [1:0] ST_DATE     = 2'd2;

  localparam logic [2:0] REG_DATE  = 3'd0;
  localparam logic [2:0] REG_TREES = 3'd1;
  localparam logic [2:0] REG_VIB   = 3'd2;
  localparam logic [2:0] REG_GAP   = 3'd3;
  localparam logic [2:0] REG_LAT   = 3'd4;
  localparam logic [2:0] REG_LON   = 3'd5;
  localparam logic [2:0] REG_LIMIT = 3'd6;

  localparam logic [2:0] OP_LAT   = 3'd0;
  localparam logic [2:0] OP_LON   = 3'd1;
  localparam logic [2:0] OP_VIB   = 3'd2;
  localparam logic [2:0] OP_VIB_C = 3'd3;
  localparam logic [2:0] OP_GAP   = 3'd4;
  localparam logic [2:0] OP_GAP_C = 3'd5;
  localparam logic [2:0] OP_END   = 3'd6;

  typedef struct packed {
    logic       accept;
    logic       load_mul;
    logic       div_start;
    logic       div_apply;
    logic       out_load;
    logic [2:0] op;
  } hcs_cmd_t;

  typedef struct packed {
    logic in_load;
    logic tree_hit;
    logic trees_zero;
    logic div_done;
    logic out_busy;
  } hcs_stat_t;

endpackage

[design/hcs_if.sv]
// Handshake interfaces for the event and result words.
// No dependencies.
interface hcs_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [47:0]        time_ms;
  logic [31:0]        event_date;
  logic [2:0]         motion;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  modport source (output valid, operation, time_ms, event_date, motion, latitude, longitude,
                  input ready);
  modport sink   (input valid, operation, time_ms, event_date, motion, latitude, longitude,
                  output ready);
endinterface

interface hcs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        date_out;
  logic [15:0]        trees;
  logic [15:0]        mean_vibrate_cs;
  logic [15:0]        mean_gap_cs;
  logic signed [31:0] mean_latitude;
  logic signed [31:0] mean_longitude;
  modport source (output valid, status, date_out, trees, mean_vibrate_cs, mean_gap_cs,
                  mean_latitude, mean_longitude, input ready);
  modport sink   (input valid, status, date_out, trees, mean_vibrate_cs, mean_gap_cs,
                  mean_latitude, mean_longitude, output ready);
endinterface

[design/hcs_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned; and a divide-by-100
// unit taking one byte per cycle by reciprocal multiplication.
// Depends on hcs_pkg.
module hcs_div import hcs_pkg::*; #(
  parameter int DW = TimeBitsDef + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DW-1:0]       dividend_i,
  input  logic [DivisorW-1:0] divisor_i,
  output logic                done_o,
  output logic [DW-1:0]       quot_o,
  output logic [DivisorW-1:0] rem_o
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]       dvd_q;
  logic [DivisorW-1:0] rem_q;
  logic [CW-1:0]       cnt_q;
  logic                busy_q, done_q;
  logic [DivisorW:0]   trial;
  logic                fits;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], fits};
      rem_q <= fits ? DivisorW'(trial - {1'b0, divisor_i}) : trial[DivisorW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;
endmodule

module hcs_div100 import hcs_pkg::*; #(
  parameter int DW = TimeBitsDef + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [15:0]   quot_o
);
  localparam int NC = (DW + 7) / 8;
  localparam int PW = NC * 8;
  localparam int CW = $clog2(NC + 1);

  logic [PW-1:0] dvd_q, quot_q;
  logic [6:0]    rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [14:0]   part, back;
  logic [29:0]   prod;
  logic [7:0]    qd;

  // partial dividend stays below 25600, where the reciprocal is exact
  assign part = {rem_q, dvd_q[PW-1 -: 8]};
  assign prod = 30'(part) * 30'(CsRecip);
  assign qd   = prod[CsRecipShift +: 8];
  assign back = 15'(qd) * 15'(CsScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NC);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= PW'(dividend_i);
      quot_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[PW-9:0], 8'd0};
      quot_q <= {quot_q[PW-9:0], qd};
      rem_q  <= 7'(part - back);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q[15:0];
endmodule

[design/hcs_ctrl.sv]
// Controller: accepts words, sequences load and the divider operations,
// hands the result word to the output register. Depends on hcs_pkg.
module hcs_ctrl import hcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hcs_stat_t stat_i,
  output hcs_cmd_t  cmd_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD2 = 3'd1;
  localparam logic [2:0] S_DGO   = 3'd2;
  localparam logic [2:0] S_DWAIT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] op_q, op_d;
  logic       skip;

  assign skip = (((op_q == OP_LAT) || (op_q == OP_LON)) && !stat_i.tree_hit) ||
                (((op_q == OP_VIB) || (op_q == OP_GAP)) && stat_i.trees_zero);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          op_d         = OP_LAT;
          state_d      = stat_i.in_load ? S_LOAD2 : S_DGO;
        end
      end
      S_LOAD2: begin
        cmd_o.load_mul = 1'b1;
        state_d        = S_DGO;
      end
      S_DGO: begin
        if (op_q == OP_END) begin
          state_d = S_FIN;
        end else if (skip) begin
          op_d = op_q + 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.div_apply = 1'b1;
          op_d            = op_q + 1'b1;
          state_d         = S_DGO;
        end
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_LAT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end
endmodule

[design/hcs_dp.sv]
// Datapath: config registers, statistics state, event update, divider
// operand selection and output register. Depends on hcs_pkg, hcs_if, hcs_div.
module hcs_dp import hcs_pkg::*; #(
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  hcs_in_if.sink             in_if,
  hcs_out_if.source          out_if,
  input  hcs_cmd_t           cmd_i,
  output hcs_stat_t          stat_o
);
  localparam int TW = TIME_BITS;
  localparam int DW = TW + 1;
  localparam int XW = (TW > CfgW) ? TW : CfgW;
  localparam int PW = 39;

  logic [31:0] r_date_q, r_lat_q, r_lon_q;
  logic [15:0] r_trees_q, r_vib_q, r_gap_q;
  logic [CfgW-1:0] r_limit_q;

  logic [2:0]  tree_phase_q, prev_mot_q, gap_phase_q;
  logic [TW-1:0] vib_start_q, last_open_q, last_event_q, vib_total_q, gap_total_q;
  logic [31:0] date_q, lat_q, lon_q, lat_in_q, lon_in_q;
  logic [15:0] trees_q;
  logic        tree_hit_q;
  logic [1:0]  status_q;
  logic [31:0] prod_vib_q, prod_gap_q;
  logic [TW-1:0] rq_q;
  logic [15:0] vib_cs_q, gap_cs_q;

  logic        out_valid_q;
  logic [1:0]  o_status_q;
  logic [31:0] o_date_q, o_lat_q, o_lon_q;
  logic [15:0] o_trees_q, o_vib_q, o_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_date_q  <= '0;
      r_trees_q <= '0;
      r_vib_q   <= '0;
      r_gap_q   <= '0;
      r_lat_q   <= '0;
      r_lon_q   <= '0;
      r_limit_q <= GapLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DATE:  r_date_q  <= cfg_data_i[31:0];
        REG_TREES: r_trees_q <= cfg_data_i[15:0];
        REG_VIB:   r_vib_q   <= cfg_data_i[15:0];
        REG_GAP:   r_gap_q   <= cfg_data_i[15:0];
        REG_LAT:   r_lat_q   <= cfg_data_i[31:0];
        REG_LON:   r_lon_q   <= cfg_data_i[31:0];
        REG_LIMIT: r_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // event update
  logic [TW+TimeInW-1:0] t_ext;
  logic [TW-1:0] t, d_gap, d_vib;
  logic [2:0]    mot;
  logic          vib_now, vib_prev, tree_evt;
  logic [XW-1:0] d_cmp, lim_cmp;

  assign t_ext    = {{TW{1'b0}}, in_if.time_ms};
  assign t        = t_ext[TW-1:0];
  assign mot      = (in_if.motion > MOT_OPENING) ? MOT_STILL : in_if.motion;
  assign vib_now  = mot == MOT_VIBRATING;
  assign vib_prev = prev_mot_q == MOT_VIBRATING;
  assign d_vib    = t - vib_start_q;
  assign d_gap    = t - last_open_q;
  assign d_cmp    = XW'(d_gap);
  assign lim_cmp  = XW'(r_limit_q);
  assign tree_evt = (mot == MOT_OPENING) && (tree_phase_q == MOT_VIBRATING);

  // load products
  logic [PW-1:0] tot_vib_w, tot_gap_w;
  logic [TW+PW-1:0] tot_vib_x, tot_gap_x;
  assign tot_vib_w = PW'(prod_vib_q) * PW'(CsScale);
  assign tot_gap_w = PW'(prod_gap_q) * PW'(CsScale);
  assign tot_vib_x = {{TW{1'b0}}, tot_vib_w};
  assign tot_gap_x = {{TW{1'b0}}, tot_gap_w};

  // divider operands
  logic signed [32:0] diff;
  logic [32:0]   diff_mag;
  logic          diff_neg;
  logic [DW-1:0] dvd;
  logic [DivisorW-1:0] dvs;
  logic          div_done, d_done, c_done, const_op;
  logic [DW-1:0] quot;
  logic [DivisorW-1:0] rem;
  logic [15:0]   c_quot;
  logic [DW-1:0] rounded;
  logic [31:0]   q32, mean_new;

  assign diff     = (cmd_i.op == OP_LAT) ? ($signed({lat_in_q[31], lat_in_q}) -
                                            $signed({lat_q[31], lat_q}))
                                         : ($signed({lon_in_q[31], lon_in_q}) -
                                            $signed({lon_q[31], lon_q}));
  assign diff_neg = diff[32];
  assign diff_mag = diff_neg ? 33'(-diff) : diff;

  always_comb begin
    dvd = '0;
    dvs = trees_q;
    case (cmd_i.op)
      OP_LAT, OP_LON: dvd = DW'(diff_mag);
      OP_VIB:   dvd = DW'(vib_total_q);
      OP_GAP:   dvd = DW'(gap_total_q);
      OP_VIB_C: dvd = trees_q == '0 ? DW'(vib_total_q) : DW'(rq_q);
      OP_GAP_C: dvd = trees_q == '0 ? DW'(gap_total_q) : DW'(rq_q);
      default: ;
    endcase
  end

  // divisions by 100 go to the reciprocal unit
  assign const_op = (cmd_i.op == OP_VIB_C) || (cmd_i.op == OP_GAP_C);
  assign div_done = const_op ? c_done : d_done;

  hcs_div #(.DW(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i    (cmd_i.div_start && !const_op),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (d_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  hcs_div100 #(.DW(DW)) u_div100 (
    .clk_i, .rst_ni,
    .start_i    (cmd_i.div_start && const_op),
    .dividend_i (dvd),
    .done_o     (c_done),
    .quot_o     (c_quot)
  );

  assign rounded  = ({rem, 1'b0} >= {1'b0, trees_q}) ? quot + 1'b1 : quot;
  assign q32      = quot[31:0];
  assign mean_new = ((cmd_i.op == OP_LAT) ? lat_q : lon_q) + (diff_neg ? -q32 : q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_phase_q <= MOT_OPENING;
      prev_mot_q   <= MOT_STILL;
      gap_phase_q  <= MOT_CLOSING;
      vib_start_q  <= '0;
      last_open_q  <= '0;
      last_event_q <= '0;
      vib_total_q  <= '0;
      gap_total_q  <= '0;
      date_q       <= '0;
      trees_q      <= '0;
      lat_q        <= '0;
      lon_q        <= '0;
      tree_hit_q   <= 1'b0;
      status_q     <= ST_OK;
    end else if (cmd_i.accept) begin
      tree_hit_q <= 1'b0;
      status_q   <= ST_OK;
      if (in_if.operation) begin
        tree_phase_q <= MOT_OPENING;
        prev_mot_q   <= MOT_STILL;
        gap_phase_q  <= MOT_CLOSING;
        vib_start_q  <= '0;
        last_open_q  <= '0;
        last_event_q <= '0;
        date_q       <= r_date_q;
        trees_q      <= r_trees_q;
        lat_q        <= r_lat_q;
        lon_q        <= r_lon_q;
      end else if (t < last_event_q) begin
        status_q <= ST_BACKWARD;
      end else begin
        last_event_q <= t;
        if (in_if.event_date != date_q && date_q != '0) begin
          status_q <= ST_DATE;
        end else begin
          date_q     <= in_if.event_date;
          prev_mot_q <= mot;
          if (!vib_prev && vib_now) vib_start_q <= t;
          if (vib_prev && !vib_now) vib_total_q <= vib_total_q + d_vib;
          if (vib_now) begin
            gap_phase_q <= MOT_VIBRATING;
          end else if (mot == MOT_OPENING && gap_phase_q == MOT_VIBRATING) begin
            last_open_q <= t;
            gap_phase_q <= MOT_OPENING;
          end else if (mot == MOT_CLOSING && gap_phase_q == MOT_OPENING) begin
            if (d_cmp < lim_cmp) gap_total_q <= gap_total_q + d_gap;
            gap_phase_q <= MOT_CLOSING;
          end
          if (mot == MOT_CLOSING && tree_phase_q == MOT_OPENING) begin
            tree_phase_q <= MOT_CLOSING;
          end else if (vib_now && tree_phase_q == MOT_CLOSING) begin
            tree_phase_q <= MOT_VIBRATING;
          end else if (tree_evt) begin
            tree_phase_q <= MOT_OPENING;
          end
          if (tree_evt && trees_q != TreeMax) begin
            trees_q    <= trees_q + 1'b1;
            tree_hit_q <= 1'b1;
          end
        end
      end
    end else if (cmd_i.load_mul) begin
      vib_total_q <= tot_vib_x[TW-1:0];
      gap_total_q <= tot_gap_x[TW-1:0];
    end else if (cmd_i.div_apply) begin
      if (cmd_i.op == OP_LAT) lat_q <= mean_new;
      if (cmd_i.op == OP_LON) lon_q <= mean_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lat_in_q   <= in_if.latitude;
      lon_in_q   <= in_if.longitude;
      prod_vib_q <= r_trees_q * r_vib_q;
      prod_gap_q <= r_trees_q * r_gap_q;
    end
    if (cmd_i.div_apply) begin
      case (cmd_i.op)
        OP_VIB, OP_GAP: rq_q     <= rounded[TW-1:0];
        OP_VIB_C:       vib_cs_q <= c_quot;
        OP_GAP_C:       gap_cs_q <= c_quot;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      o_status_q <= status_q;
      o_date_q   <= date_q;
      o_trees_q  <= trees_q;
      o_vib_q    <= vib_cs_q;
      o_gap_q    <= gap_cs_q;
      o_lat_q    <= lat_q;
      o_lon_q    <= lon_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.in_load    = in_if.operation;
  assign stat_o.tree_hit   = tree_hit_q;
  assign stat_o.trees_zero = trees_q == '0;
  assign stat_o.div_done   = div_done;
  assign stat_o.out_busy   = out_valid_q && !out_if.ready;

  assign out_if.valid           = out_valid_q;
  assign out_if.status          = o_status_q;
  assign out_if.date_out        = o_date_q;
  assign out_if.trees           = o_trees_q;
  assign out_if.mean_vibrate_cs = o_vib_q;
  assign out_if.mean_gap_cs     = o_gap_q;
  assign out_if.mean_latitude   = o_lat_q;
  assign out_if.mean_longitude  = o_lon_q;
endmodule

[design/harvest_cycle_statistics.sv]
// Top level of harvest_cycle_statistics: controller plus datapath.
// Depends on hcs_pkg, hcs_if, hcs_ctrl, hcs_dp.
//
//   port      | dir | word
//   in_if     | in  | operation, time_ms, event_date, motion, latitude, longitude
//   out_if    | out | status, date_out, trees, mean_*
//   cfg_*     | in  | write enable, register index, data
//
// One word at a time: an accept step, plus a multiply step for a load; then the
// latitude, longitude, vibrate and gap divisions by the tree count, the latter two
// each followed by a division by 100. Latitude and longitude are skipped without a
// new tree, vibrate and gap when the tree count is zero; then the output register.
// Reset clears the statistics but not the vibrate/gap means. A waiting result
// does not stop the next word; only its final hand-off waits on out_if.ready.
module harvest_cycle_statistics import hcs_pkg::*; #(
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  hcs_in_if.sink             in_if,
  hcs_out_if.source          out_if
);
  hcs_cmd_t  cmd;
  hcs_stat_t stat;

  hcs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hcs_dp #(.TIME_BITS(TIME_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if, .out_if,
    .cmd_i  (cmd),
    .stat_o (stat)
  );
endmodule
